@@ src/elu_pkg.sv @@
// Shared types, constants and helpers for the ELU forward/backward pipeline.
// No dependencies; every other file in src/ refers to it by scoped names.
`default_nettype none

package elu_pkg;

	localparam int DATA_W        = 16;
	localparam int SCALE_W       = 15;
	localparam int FRAC_BITS_DEF = 12;
	localparam logic [SCALE_W-1:0] SCALE_RST = 15'd4096;

	// Q30 exponential datapath
	localparam int Q_BITS = 30;
	localparam int R_W    = 30;        // remainder after ln2 reduction, below ln2
	localparam int T_W    = 31;        // Horner term, at most 1.0
	localparam int M30_W  = 35;        // clamped magnitude, at most 16.0
	localparam int N_W    = 5;         // ln2 multiples, at most 23
	localparam int N_MAX  = 23;
	localparam int TAYLOR_TERMS = 10;
	localparam logic [T_W-1:0]   Q30_ONE   = 31'h4000_0000;
	localparam logic [R_W-1:0]   Q30_LN2   = 30'd744261118;
	localparam logic [M30_W-1:0] Q30_CLAMP = 35'h4_0000_0000;

	// range reduction + one three-stage unit per Taylor term + post stages
	localparam int PIPE_DEPTH = 3 + 3 * TAYLOR_TERMS + 3;

	// per-beat side information carried down the pipeline
	typedef struct packed {
		logic                     func;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] grad;
	} elu_side_t;

	// n * ln2 in Q30
	function automatic logic [M30_W-1:0] ln2_mult(input logic [N_W-1:0] n);
		return M30_W'(n) * M30_W'(Q30_LN2);
	endfunction

endpackage

`default_nettype wire

@@ src/elu_rng.sv @@
// Range reduction for exp(-m): negate, move to Q30, clamp, split into n*ln2 + r.
// Depends on elu_pkg.
`default_nettype none

module elu_rng #(
	parameter int FRAC_BITS = elu_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  elu_pkg::elu_side_t               in_side,
	output logic                             out_valid,
	input  wire                              out_ready,
	output elu_pkg::elu_side_t               out_side,
	output logic [elu_pkg::R_W-1:0]          out_r,
	output logic [elu_pkg::N_W-1:0]          out_n
);

	localparam int SH    = elu_pkg::Q_BITS - FRAC_BITS;
	localparam int WIDE  = elu_pkg::DATA_W + SH;
	// compare width that holds both the shifted magnitude and the clamp value
	localparam int CMP_W = (WIDE > elu_pkg::M30_W) ? WIDE : elu_pkg::M30_W;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	elu_pkg::elu_side_t side_s1, side_s2, side_s3;
	logic [elu_pkg::M30_W-1:0] m30_s1, m30_s2;
	logic [elu_pkg::N_W-1:0]   n_s2, n_s3;
	logic [elu_pkg::R_W-1:0]   r_s3;

	logic [elu_pkg::DATA_W:0]   neg_ext;
	logic [WIDE-1:0]            m_wide;
	logic [elu_pkg::M30_W-1:0]  m30_nxt;
	logic [elu_pkg::N_W-1:0]    n_nxt;
	logic [elu_pkg::M30_W-1:0]  r_full;

	// bubble-collapsing stage enables
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// s1: magnitude of a negative input, in Q30, clamped to 16.0
	always_comb begin
		neg_ext = (elu_pkg::DATA_W+1)'(0) - {in_side.value[elu_pkg::DATA_W-1], in_side.value};
		m_wide  = WIDE'(neg_ext[elu_pkg::DATA_W-1:0]) << SH;
		if (CMP_W'(m_wide) > CMP_W'(elu_pkg::Q30_CLAMP)) m30_nxt = elu_pkg::Q30_CLAMP;
		else m30_nxt = elu_pkg::M30_W'(m_wide);
	end

	// s2: n = floor(m / ln2) by a compare against each multiple
	always_comb begin
		n_nxt = '0;
		for (int k = 1; k <= elu_pkg::N_MAX; k++) begin
			if (m30_s1 >= elu_pkg::ln2_mult(elu_pkg::N_W'(k))) n_nxt = elu_pkg::N_W'(k);
		end
	end

	// s3: remainder
	assign r_full = m30_s2 - elu_pkg::ln2_mult(n_s2);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= in_side;
			m30_s1  <= m30_nxt;
		end
		if (en_s2) begin
			side_s2 <= side_s1;
			m30_s2  <= m30_s1;
			n_s2    <= n_nxt;
		end
		if (en_s3) begin
			side_s3 <= side_s2;
			n_s3    <= n_s2;
			r_s3    <= r_full[elu_pkg::R_W-1:0];
		end
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
	assign out_r     = r_s3;
	assign out_n     = n_s3;

endmodule

`default_nettype wire

@@ src/elu_tstep.sv @@
// One Horner step of the exp(-r) Taylor series: t' = 1.0 - floor(floor(r*t/2^30)/K).
// Three stages: product, reciprocal estimate, correction. Depends on elu_pkg.
`default_nettype none

module elu_tstep #(
	parameter int unsigned K = 1
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  elu_pkg::elu_side_t               in_side,
	input  wire  [elu_pkg::R_W-1:0]          in_r,
	input  wire  [elu_pkg::T_W-1:0]          in_t,
	input  wire  [elu_pkg::N_W-1:0]          in_n,
	output logic                             out_valid,
	input  wire                              out_ready,
	output elu_pkg::elu_side_t               out_side,
	output logic [elu_pkg::R_W-1:0]          out_r,
	output logic [elu_pkg::T_W-1:0]          out_t,
	output logic [elu_pkg::N_W-1:0]          out_n
);

	localparam int PW = elu_pkg::R_W;                      // width of the product term
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K); // floor(2^32 / K)

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	elu_pkg::elu_side_t side_s1, side_s2, side_s3;
	logic [elu_pkg::R_W-1:0] r_s1, r_s2, r_s3;
	logic [elu_pkg::N_W-1:0] n_s1, n_s2, n_s3;
	logic [PW-1:0]           p_s1, p_s2;
	logic [PW-1:0]           q0_s2;
	logic [elu_pkg::T_W-1:0] t_s3;

	logic [60:0] prod_rt;
	logic [62:0] prod_rc;
	logic [33:0] qk;
	logic [33:0] rem;
	logic [PW-1:0] q;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// s1: r*t in Q30; at most r
	assign prod_rt = 61'(in_r) * 61'(in_t);

	// s2: quotient estimate, at most one below floor(p/K)
	assign prod_rc = 63'(p_s1) * 63'(RECIP);

	// s3: one correction step, then the next term
	always_comb begin
		qk  = 34'(q0_s2) * 34'(K);
		rem = 34'(p_s2) - qk;
		if (rem >= 34'(K)) q = q0_s2 + PW'(1);
		else q = q0_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= in_side;
			r_s1    <= in_r;
			n_s1    <= in_n;
			p_s1    <= prod_rt[elu_pkg::Q_BITS +: PW];
		end
		if (en_s2) begin
			side_s2 <= side_s1;
			r_s2    <= r_s1;
			n_s2    <= n_s1;
			p_s2    <= p_s1;
			q0_s2   <= prod_rc[32 +: PW];
		end
		if (en_s3) begin
			side_s3 <= side_s2;
			r_s3    <= r_s2;
			n_s3    <= n_s2;
			t_s3    <= elu_pkg::Q30_ONE - elu_pkg::T_W'(q);
		end
	end

	assign out_valid = v_s3;
	assign out_side  = side_s3;
	assign out_r     = r_s3;
	assign out_t     = t_s3;
	assign out_n     = n_s3;

endmodule

`default_nettype wire

@@ src/elu_post.sv @@
// Final stages: exp shift, shared signed multiplier for alpha*(1-e) or g*(alpha+y),
// rounding, saturation and pass-through select. Depends on elu_pkg.
`default_nettype none

module elu_post #(
	parameter int FRAC_BITS = elu_pkg::FRAC_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  [elu_pkg::SCALE_W-1:0]          scale,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  elu_pkg::elu_side_t                   in_side,
	input  wire  [elu_pkg::T_W-1:0]              in_t,
	input  wire  [elu_pkg::N_W-1:0]              in_n,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [elu_pkg::DATA_W-1:0]    out_result
);

	localparam int AW = 18;
	localparam int BW = 32;
	localparam int PW = AW + BW;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	elu_pkg::elu_side_t side_s1, side_s2;
	logic signed [AW-1:0] op_a_s1;
	logic signed [BW-1:0] op_b_s1;
	logic signed [PW-1:0] prod_s2;
	logic signed [elu_pkg::DATA_W-1:0] res_s3;

	logic [elu_pkg::T_W-1:0] e;
	logic [elu_pkg::T_W-1:0] d;
	logic signed [AW-1:0]    s;
	logic signed [AW-1:0]    op_a;
	logic signed [BW-1:0]    op_b;
	logic [PW-1:0]           fwd_sum;
	logic [elu_pkg::DATA_W-1:0] mag;
	logic signed [PW:0]      rnd;
	logic signed [PW:0]      bq;
	logic signed [elu_pkg::DATA_W-1:0] res_nxt;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// s1: d = 1 - exp(-r)/2^n, s = alpha + y, pick multiplier operands
	always_comb begin
		e = in_t >> in_n;
		d = elu_pkg::Q30_ONE - e;
		s = $signed(AW'(scale)) + AW'(in_side.value);
		if (in_side.func) begin
			op_a = s;
			op_b = BW'(in_side.grad);
		end else begin
			op_a = $signed(AW'(scale));
			op_b = $signed(BW'(d));
		end
	end

	// s3: round, saturate, select pass-through
	always_comb begin
		fwd_sum = PW'(prod_s2) + (PW'(1) << (elu_pkg::Q_BITS - 1));
		mag     = fwd_sum[elu_pkg::Q_BITS +: elu_pkg::DATA_W];
		rnd     = (PW+1)'(prod_s2) + $signed((PW+1)'(1) << (FRAC_BITS - 1));
		bq      = rnd >>> FRAC_BITS;
		if (!side_s2.value[elu_pkg::DATA_W-1]) begin
			res_nxt = side_s2.func ? side_s2.grad : side_s2.value;
		end else if (!side_s2.func) begin
			res_nxt = $signed(elu_pkg::DATA_W'(0) - mag);
		end else if (bq > $signed((PW+1)'(32767))) begin
			res_nxt = 16'sh7FFF;
		end else if (bq < $signed(-(PW+1)'(32768))) begin
			res_nxt = 16'sh8000;
		end else begin
			res_nxt = bq[elu_pkg::DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			side_s1 <= in_side;
			op_a_s1 <= op_a;
			op_b_s1 <= op_b;
		end
		if (en_s2) begin
			side_s2 <= side_s1;
			prod_s2 <= PW'(op_a_s1) * PW'(op_b_s1);
		end
		if (en_s3) begin
			res_s3  <= res_nxt;
		end
	end

	assign out_valid  = v_s3;
	assign out_result = res_s3;

endmodule

`default_nettype wire

@@ src/elu_activation_fwd_bwd.sv @@
// Top level of the ELU forward/backward pipeline: alpha register, range reduction,
// ten Horner steps and the output stages. Depends on elu_pkg, elu_rng, elu_tstep, elu_post.
//
//   port group   dir  beat contents
//   s_axis  s_*  in   tdata = value[15:0], grad[31:16]; tuser = func
//   m_axis  m_*  out  tdata = result[15:0]
//   cfg     cfg_ in   alpha (unsigned, FRAC_BITS fraction) on cfg_we
//
// One beat in and one beat out per cycle unless m_tready stalls. Depth is set by the
// multiply/correct chain: 3 range reduction, 3 per Taylor term for 10 terms, 3 output.
// Reset clears all valid bits and sets alpha to 1.0 at 12 fraction bits.
// A stall on m_tready backs up stage by stage; empty stages keep filling, so
// s_tready drops only when every stage holds a beat.
`default_nettype none

module elu_activation_fwd_bwd #(
	parameter int FRAC_BITS = elu_pkg::FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [31:0]                  s_tdata,   // value[15:0], grad[31:16]
	input  wire                          s_tuser,   // func
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [15:0]                  m_tdata,   // result[15:0]
	input  wire                          cfg_we,
	input  wire  [elu_pkg::SCALE_W-1:0]  cfg_wdata
);

	localparam int NT = elu_pkg::TAYLOR_TERMS;

	logic [elu_pkg::SCALE_W-1:0] elu_scale_q;

	elu_pkg::elu_side_t in_side;

	logic                      c_valid [NT+1];
	logic                      c_ready [NT+1];
	elu_pkg::elu_side_t        c_side  [NT+1];
	logic [elu_pkg::R_W-1:0]   c_r     [NT+1];
	logic [elu_pkg::T_W-1:0]   c_t     [NT+1];
	logic [elu_pkg::N_W-1:0]   c_n     [NT+1];

	logic signed [elu_pkg::DATA_W-1:0] result;

	// alpha register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) elu_scale_q <= elu_pkg::SCALE_RST;
		else if (cfg_we) elu_scale_q <= cfg_wdata;
	end

	// unpack input beat
	always_comb begin
		in_side.func  = s_tuser;
		in_side.value = $signed(s_tdata[15:0]);
		in_side.grad  = $signed(s_tdata[31:16]);
	end

	elu_rng #(.FRAC_BITS(FRAC_BITS)) u_rng (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_side   (in_side),
		.out_valid (c_valid[0]),
		.out_ready (c_ready[0]),
		.out_side  (c_side[0]),
		.out_r     (c_r[0]),
		.out_n     (c_n[0])
	);

	// Horner series starts from 1.0 at the highest term
	assign c_t[0] = elu_pkg::Q30_ONE;

	for (genvar i = 0; i < NT; i++) begin : g_term
		elu_tstep #(.K(NT - i)) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[i]),
			.in_ready  (c_ready[i]),
			.in_side   (c_side[i]),
			.in_r      (c_r[i]),
			.in_t      (c_t[i]),
			.in_n      (c_n[i]),
			.out_valid (c_valid[i+1]),
			.out_ready (c_ready[i+1]),
			.out_side  (c_side[i+1]),
			.out_r     (c_r[i+1]),
			.out_t     (c_t[i+1]),
			.out_n     (c_n[i+1])
		);
	end

	elu_post #(.FRAC_BITS(FRAC_BITS)) u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale      (elu_scale_q),
		.in_valid   (c_valid[NT]),
		.in_ready   (c_ready[NT]),
		.in_side    (c_side[NT]),
		.in_t       (c_t[NT]),
		.in_n       (c_n[NT]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = result;

endmodule

`default_nettype wire

@@ src/elu_chk.sv @@
// Port-level checker for elu_activation_fwd_bwd and the bind that attaches it.
// Depends on elu_pkg for the pipeline depth.
`default_nettype none

module elu_chk #(
	parameter int DEPTH = elu_pkg::PIPE_DEPTH
) (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata
);

	localparam int CW = $clog2(DEPTH + 2);

	logic [CW-1:0] inflight_q;
	logic in_beat, out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	// beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inflight_q <= '0;
		else if (in_beat && !out_beat) inflight_q <= inflight_q + CW'(1);
		else if (!in_beat && out_beat) inflight_q <= inflight_q - CW'(1);
	end

	// no output beat without a pending input beat
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (inflight_q != '0))
		else $error("output beat with nothing in flight");

	// occupancy never exceeds the pipeline depth
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(DEPTH))
		else $error("more beats in flight than pipeline stages");

	// input is refused only behind a stalled output
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input refused while output not stalled");

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output beat changed");

endmodule

bind elu_activation_fwd_bwd elu_chk #(.DEPTH(elu_pkg::PIPE_DEPTH)) u_elu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
